### sv/ansi_sgr_color_decoder_defines.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ANSI_SGR_COLOR_DECODER_DEFINES_SVH
`define ANSI_SGR_COLOR_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define ASGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and masked during reset.
`define ASGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/asgr_pkg.sv
package asgr_pkg;

  localparam int DATA_W     = 8;
  localparam int FG_W       = 4;
  localparam int COLOR_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_ONLY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_HIDDEN = 1'b1;

  // Byte codes that steer the parser.
  localparam logic [DATA_W-1:0] ESC_BYTE   = 8'h1B;
  localparam logic [DATA_W-1:0] LBRKT_BYTE = 8'h5B;
  localparam logic [DATA_W-1:0] M_BYTE     = 8'h6D;
  localparam logic [DATA_W-1:0] ZERO_BYTE  = 8'h30;
  localparam logic [DATA_W-1:0] NINE_BYTE  = 8'h39;

  // SGR parameter values.
  localparam logic [DATA_W-1:0] SGR_RESET   = 8'd0;
  localparam logic [DATA_W-1:0] SGR_BOLD    = 8'd1;
  localparam logic [DATA_W-1:0] SGR_FG_LO   = 8'd30;
  localparam logic [DATA_W-1:0] SGR_FG_HI   = 8'd37;
  localparam logic [DATA_W-1:0] SGR_BG_LO   = 8'd40;
  localparam logic [DATA_W-1:0] SGR_BG_HI   = 8'd47;
  localparam logic [DATA_W-1:0] PARAM_SAT   = 8'd255;

  // Default colors after a line start or an SGR reset.
  localparam logic [COLOR_W-1:0] FORE_DEFAULT = 3'd7;
  localparam logic [COLOR_W-1:0] BACK_DEFAULT = 3'd0;

  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_PARAM = 2'd2,
    MODE_SKIP  = 2'd3
  } parse_mode_t;

endpackage

### sv/asgr_channels.sv
interface asgr_in_if;
  import asgr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              line_start;

  modport source (output valid, output data_byte, output line_start, input ready);
  modport sink   (input valid, input data_byte, input line_start, output ready);
endinterface

interface asgr_out_if;
  import asgr_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  char_byte;
  logic [FG_W-1:0]    fg_index;
  logic [COLOR_W-1:0] bg_index;
  logic               hidden_invert;

  modport source (output valid, output char_byte, output fg_index, output bg_index,
                  output hidden_invert, input ready);
  modport sink   (input valid, input char_byte, input fg_index, input bg_index,
                  input hidden_invert, output ready);
endinterface

### sv/ansi_sgr_color_decoder.sv
// ANSI SGR color decoder. Text bytes arrive one per beat on in_ch, each with a
// line_start flag that returns the colors to foreground 7, background 0, bold
// off and drops any escape sequence in progress. Non-ESC text-mode bytes leave on
// out_ch with their foreground palette index (bold adds 8 unless dark_only is
// set), background index and a hidden-text flag that is raised when
// show_hidden is set and both indexes match. ESC '[' opens a parameter list of
// decimal numbers (saturating at 255) split by any non-digit byte and closed
// by 'm'; 0 resets, 1 sets bold, 30-37 and 40-47 pick the foreground and
// background. ESC followed by any other byte swallows input through the next
// 'm'. Escape bytes produce no output beat. The block accepts one byte per
// clock for as long as the result side keeps up; a byte that produces a
// result passes the input register and then the result register. The color
// and parser state update between those two registers is combinational and
// is what sets the one-byte-per-clock figure. A byte that produces nothing
// is retired even while the result register is stalled. The configuration
// registers are meant to be written only while the block is idle.
module ansi_sgr_color_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  asgr_in_if.sink                          in_ch,
  asgr_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [asgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asgr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import asgr_pkg::*;

`include "ansi_sgr_color_decoder_defines.svh"

  // Configuration registers.
  logic dark_only_r;
  logic show_hidden_r;

  // Input register: holds one accepted byte until it is decoded.
  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_byte_r;
  logic              s1_line_start_r;

  // Parser and color state.
  parse_mode_t        mode_r,       mode_nxt;
  logic [COLOR_W-1:0] fore_r,       fore_nxt;
  logic [COLOR_W-1:0] back_r,       back_nxt;
  logic               bold_r,       bold_nxt;
  logic [DATA_W-1:0]  param_r,      param_nxt;
  logic               param_seen_r, param_seen_nxt;

  // Result register.
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_char_r;
  logic [FG_W-1:0]    out_fg_r;
  logic [COLOR_W-1:0] out_bg_r;
  logic               out_hidden_r;

  // State as seen by the byte in the input register, after a line start.
  parse_mode_t        eff_mode;
  logic [COLOR_W-1:0] eff_fore;
  logic [COLOR_W-1:0] eff_back;
  logic               eff_bold;
  logic [DATA_W-1:0]  eff_param;
  logic               eff_param_seen;

  logic                s1_is_digit;
  logic [DATA_W+3:0]   param_acc;
  logic                s1_emits;
  logic                s1_fire;
  logic                s1_advance;
  logic [FG_W-1:0]     fg_calc;
  logic                hidden_calc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_only_r   <= 1'b0;
      show_hidden_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DARK_ONLY:   dark_only_r   <= cfg_wdata[0];
        CFG_SHOW_HIDDEN: show_hidden_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (s1_line_start_r) begin
      eff_mode       = MODE_TEXT;
      eff_fore       = FORE_DEFAULT;
      eff_back       = BACK_DEFAULT;
      eff_bold       = 1'b0;
      eff_param      = '0;
      eff_param_seen = 1'b0;
    end else begin
      eff_mode       = mode_r;
      eff_fore       = fore_r;
      eff_back       = back_r;
      eff_bold       = bold_r;
      eff_param      = param_r;
      eff_param_seen = param_seen_r;
    end
  end

  assign s1_is_digit = (s1_byte_r >= ZERO_BYTE) && (s1_byte_r <= NINE_BYTE);

  // param * 10 + digit, as two shifted adds; the digit value is the low nibble.
  assign param_acc = {1'b0, eff_param, 3'b000} + {3'b000, eff_param, 1'b0}
                   + {8'h00, s1_byte_r[3:0]};

  always_comb begin
    mode_nxt       = eff_mode;
    fore_nxt       = eff_fore;
    back_nxt       = eff_back;
    bold_nxt       = eff_bold;
    param_nxt      = eff_param;
    param_seen_nxt = eff_param_seen;
    s1_emits       = 1'b0;
    unique case (eff_mode)
      MODE_TEXT: begin
        if (s1_byte_r == ESC_BYTE) begin
          mode_nxt = MODE_ESC;
        end else begin
          s1_emits = 1'b1;
        end
      end
      MODE_ESC: begin
        if (s1_byte_r == LBRKT_BYTE) begin
          mode_nxt       = MODE_PARAM;
          param_nxt      = '0;
          param_seen_nxt = 1'b0;
        end else begin
          mode_nxt = MODE_SKIP;
        end
      end
      MODE_PARAM: begin
        if (s1_is_digit) begin
          param_nxt      = (param_acc > {4'h0, PARAM_SAT}) ? PARAM_SAT
                                                           : param_acc[DATA_W-1:0];
          param_seen_nxt = 1'b1;
        end else begin
          // A non-digit closes the current parameter; apply it if it had digits.
          if (eff_param_seen) begin
            if (eff_param == SGR_RESET) begin
              fore_nxt = FORE_DEFAULT;
              back_nxt = BACK_DEFAULT;
              bold_nxt = 1'b0;
            end else begin
              if (eff_param == SGR_BOLD) begin
                bold_nxt = 1'b1;
              end
              if (eff_param >= SGR_FG_LO && eff_param <= SGR_FG_HI) begin
                fore_nxt = COLOR_W'(eff_param - SGR_FG_LO);
              end else if (eff_param >= SGR_BG_LO && eff_param <= SGR_BG_HI) begin
                back_nxt = COLOR_W'(eff_param - SGR_BG_LO);
              end
            end
          end
          param_nxt      = '0;
          param_seen_nxt = 1'b0;
          if (s1_byte_r == M_BYTE) begin
            mode_nxt = MODE_TEXT;
          end
        end
      end
      MODE_SKIP: begin
        if (s1_byte_r == M_BYTE) begin
          mode_nxt = MODE_TEXT;
        end
      end
      default: ;
    endcase
  end

  assign fg_calc     = {eff_bold & ~dark_only_r, eff_fore};
  assign hidden_calc = show_hidden_r && (fg_calc == {1'b0, eff_back});

  // A byte with no result retires at once; one with a result needs room in
  // the result register.
  assign s1_advance   = !s1_emits || !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && s1_advance;
  assign in_ch.ready  = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r       <= in_ch.data_byte;
      s1_line_start_r <= in_ch.line_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_TEXT;
      fore_r       <= FORE_DEFAULT;
      back_r       <= BACK_DEFAULT;
      bold_r       <= 1'b0;
      param_r      <= '0;
      param_seen_r <= 1'b0;
    end else if (s1_fire) begin
      mode_r       <= mode_nxt;
      fore_r       <= fore_nxt;
      back_r       <= back_nxt;
      bold_r       <= bold_nxt;
      param_r      <= param_nxt;
      param_seen_r <= param_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_emits) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emits) begin
      out_char_r   <= s1_byte_r;
      out_fg_r     <= fg_calc;
      out_bg_r     <= eff_back;
      out_hidden_r <= hidden_calc;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.char_byte     = out_char_r;
  assign out_ch.fg_index      = out_fg_r;
  assign out_ch.bg_index      = out_bg_r;
  assign out_ch.hidden_invert = out_hidden_r;

  // A bright foreground can never match a background index.
  `ASGR_ASSERT_NOW(a_bright_not_hidden, out_valid_r && out_fg_r[FG_W-1], !out_hidden_r,
                   "hidden flag raised on a bright foreground")
  // Back-pressure toward the source only comes from a held byte.
  `ASGR_ASSERT_NOW(a_stall_needs_byte, !in_ch.ready, s1_valid_r && s1_emits && out_valid_r,
                   "input stalled without a pending result")
  // ESC in text mode always moves the parser to the escape state.
  `ASGR_ASSERT_NEXT(a_esc_enters_escape,
                    s1_fire && eff_mode == MODE_TEXT && s1_byte_r == ESC_BYTE,
                    mode_r == MODE_ESC, "ESC in text did not open an escape")

endmodule

### verif/tb_ansi_sgr_color_decoder.sv
`timescale 1ns / 100ps

module tb_ansi_sgr_color_decoder;
  import asgr_pkg::*;

  // The run is cut off at this many clocks if it has not ended by itself.
  localparam int CYCLE_LIMIT  = 400000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES  = 200;
  // Random bytes sent in each configuration phase.
  localparam int PHASE_BYTES  = 345;
  // Clocks to let in-flight bytes retire after the last glyph has arrived.
  localparam int SETTLE_TICKS = 4;

  // One drawn character as it leaves the decoder.
  typedef struct packed {
    logic [DATA_W-1:0]  ch;
    logic [FG_W-1:0]    fg;
    logic [COLOR_W-1:0] bg;
    logic               hid;
  } glyph_t;

  // Tracks the SGR color state of the line being decoded and keeps the glyphs
  // that the decoder still owes, in order.
  class sgr_color_tracker;
    parse_mode_t        mode;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    logic               bold;
    logic [DATA_W-1:0]  acc;
    logic               acc_seen;
    logic               dark_only;
    logic               show_hidden;
    glyph_t             pending_glyphs[$];
    int                 failures;
    int                 reported;

    function new();
      dark_only   = 1'b0;
      show_hidden = 1'b0;
      failures    = 0;
      reported    = 0;
      clear_line();
    endfunction

    function void clear_line();
      mode     = MODE_TEXT;
      fore     = FORE_DEFAULT;
      back     = BACK_DEFAULT;
      bold     = 1'b0;
      acc      = '0;
      acc_seen = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_DARK_ONLY) dark_only = val[0];
      else if (idx == CFG_SHOW_HIDDEN) show_hidden = val[0];
    endfunction

    // Called for every byte the decoder accepts.
    function void absorb_byte(logic [DATA_W-1:0] b, logic ls);
      glyph_t g;
      int     v;
      if (ls) clear_line();
      case (mode)
        MODE_TEXT: begin
          if (b == ESC_BYTE) begin
            mode = MODE_ESC;
          end else begin
            g.ch = b;
            g.fg = {1'b0, fore};
            if (bold && !dark_only) g.fg = g.fg + 4'd8;
            g.bg  = back;
            g.hid = show_hidden && (g.fg == {1'b0, back});
            pending_glyphs = {pending_glyphs, g};
          end
        end
        MODE_ESC: begin
          if (b == LBRKT_BYTE) begin
            mode     = MODE_PARAM;
            acc      = '0;
            acc_seen = 1'b0;
          end else begin
            mode = MODE_SKIP;
          end
        end
        MODE_PARAM: begin
          if (b >= ZERO_BYTE && b <= NINE_BYTE) begin
            v        = int'(acc) * 10 + int'(b - ZERO_BYTE);
            acc      = (v > int'(PARAM_SAT)) ? PARAM_SAT : DATA_W'(v);
            acc_seen = 1'b1;
          end else begin
            // Any other byte closes the parameter; an empty one changes nothing.
            if (acc_seen) begin
              if (acc == SGR_RESET) begin
                fore = FORE_DEFAULT;
                back = BACK_DEFAULT;
                bold = 1'b0;
              end else begin
                if (acc == SGR_BOLD) bold = 1'b1;
                if (acc >= SGR_FG_LO && acc <= SGR_FG_HI) fore = COLOR_W'(acc - SGR_FG_LO);
                else if (acc >= SGR_BG_LO && acc <= SGR_BG_HI) back = COLOR_W'(acc - SGR_BG_LO);
              end
            end
            acc      = '0;
            acc_seen = 1'b0;
            if (b == M_BYTE) mode = MODE_TEXT;
          end
        end
        default: begin
          if (b == M_BYTE) mode = MODE_TEXT;
        end
      endcase
    endfunction

    // Called for every glyph the decoder delivers.
    function void match_glyph(glyph_t got);
      glyph_t want;
      if (pending_glyphs.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected glyph: char %02h fg %0d bg %0d hid %0b",
                   got.ch, got.fg, got.bg, got.hid);
        end
      end else begin
        want = pending_glyphs.pop_front();
        if (got.ch !== want.ch || got.fg !== want.fg || got.bg !== want.bg ||
            got.hid !== want.hid) begin
          failures++;
          if (reported < 10) begin
            reported++;
            $display("glyph mismatch: expected char %02h fg %0d bg %0d hid %0b",
                     want.ch, want.fg, want.bg, want.hid);
            $display("                actual   char %02h fg %0d bg %0d hid %0b",
                     got.ch, got.fg, got.bg, got.hid);
          end
        end
      end
    endfunction

    function int outstanding();
      return pending_glyphs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  asgr_in_if  in_ch ();
  asgr_out_if out_ch ();

  ansi_sgr_color_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sgr_color_tracker tracker = new();

  // When calm is set neither side adds random gaps, so the block runs at full rate unless a hold-off is requested.
  bit calm;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request;
  int bytes_sent;

  // Directed lines. Each is sent with line_start on its first byte.
  // The first one covers the byte extremes, bold with the foreground index
  // forced off the background range, '[' and ESC acting as separators, an
  // empty parameter, ESC followed by 'm' (which must skip to a later 'm'),
  // and a newline drawn as text.
  logic [DATA_W-1:0] first_line[$] = '{
    8'h00, 8'hFF, ESC_BYTE, LBRKT_BYTE, "1", LBRKT_BYTE, ";", "3", "0",
    ESC_BYTE, "4", "0", M_BYTE, "x", ESC_BYTE, M_BYTE, "q", M_BYTE, 8'h0A
  };
  // The second one runs a long digit string that saturates and selects nothing.
  logic [DATA_W-1:0] second_line[$] = '{
    ESC_BYTE, LBRKT_BYTE, "9", "9", "9", "9", M_BYTE, "Z"
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a run that hangs anywhere ends here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: checks every glyph beat and paces ready. The long hold-off is
  // counted here so the sender can keep pushing bytes while it lasts.
  initial begin
    glyph_t got;
    int     stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_ch.valid && out_ch.ready) begin
          got.ch  = out_ch.char_byte;
          got.fg  = out_ch.fg_index;
          got.bg  = out_ch.bg_index;
          got.hid = out_ch.hidden_invert;
          tracker.match_glyph(got);
        end
        if (hold_request) begin
          hold_request = 1'b0;
          stall = HOLD_CYCLES;
        end
        if (stall == 0 && !calm) stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          stall--;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Offers one byte after a random gap and returns at the edge where the beat
  // is taken. Valid is left high so a back-to-back byte keeps it up.
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic ls);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.line_start <= ls;
    do @(posedge clk); while (!in_ch.ready);
    tracker.absorb_byte(b, ls);
    bytes_sent++;
  endtask

  task automatic send_line(input logic [DATA_W-1:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == 0);
  endtask

  // Stops offering bytes until every owed glyph is in, then lets the
  // input register empty out as well.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Writes both registers in turn, dark_only first, while the block is idle.
  task automatic set_config(input logic dark, input logic show);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DARK_ONLY;
    cfg_wdata <= dark;
    tracker.write_reg(CFG_DARK_ONLY, dark);
    @(posedge clk);
    cfg_index <= CFG_SHOW_HIDDEN;
    cfg_wdata <= show;
    tracker.write_reg(CFG_SHOW_HIDDEN, show);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A stray line start now and then, also in the middle of a sequence.
  function automatic logic stray_start();
    return $urandom_range(0, 49) == 0;
  endfunction

  // A separator inside the parameter list: mostly ';', otherwise any byte
  // that is neither a digit nor 'm', ESC and '[' included.
  task automatic send_separator();
    logic [DATA_W-1:0] b;
    if ($urandom_range(0, 9) < 7) begin
      b = ";";
    end else begin
      do b = DATA_W'($urandom_range(0, 255));
      while ((b >= ZERO_BYTE && b <= NINE_BYTE) || b == M_BYTE);
    end
    send_byte(b, stray_start());
  endtask

  // One parameter as decimal digits. Most values are ones the decoder acts on;
  // some are empty, some out of range and some long enough to saturate.
  task automatic send_param();
    int r;
    int v;
    int n;
    r = $urandom_range(0, 99);
    if (r < 15) v = $urandom_range(0, 1);
    else if (r < 50) v = $urandom_range(30, 37);
    else if (r < 85) v = $urandom_range(40, 47);
    else if (r < 90) v = $urandom_range(2, 255);
    else v = -1;
    if (r >= 95) begin
      n = $urandom_range(3, 6);
      repeat (n) send_byte(DATA_W'(ZERO_BYTE + $urandom_range(0, 9)), stray_start());
    end else if (v >= 0) begin
      if ($urandom_range(0, 9) == 0) send_byte(ZERO_BYTE, stray_start());
      if (v >= 100) send_byte(DATA_W'(ZERO_BYTE + v / 100), stray_start());
      if (v >= 10) send_byte(DATA_W'(ZERO_BYTE + (v / 10) % 10), stray_start());
      send_byte(DATA_W'(ZERO_BYTE + v % 10), stray_start());
    end
  endtask

  // One random piece of a line: a run of text, a well-formed color sequence,
  // an unknown escape that is skipped, or a lone random byte.
  task automatic send_chunk();
    int                kind;
    int                n;
    logic              ls;
    logic [DATA_W-1:0] b;
    kind = $urandom_range(0, 99);
    ls   = $urandom_range(0, 7) == 0;
    if (kind < 40) begin
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
        b = DATA_W'($urandom_range(0, 255));
        if (b == ESC_BYTE) b = " ";
        send_byte(b, (k == 0) ? ls : stray_start());
      end
    end else if (kind < 80) begin
      send_byte(ESC_BYTE, ls);
      send_byte(LBRKT_BYTE, stray_start());
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) begin
        send_param();
        if (k != n - 1) send_separator();
      end
      send_byte(M_BYTE, stray_start());
    end else if (kind < 88) begin
      send_byte(ESC_BYTE, ls);
      do b = DATA_W'($urandom_range(0, 255)); while (b == LBRKT_BYTE);
      if ($urandom_range(0, 3) == 0) b = M_BYTE;
      send_byte(b, stray_start());
      n = $urandom_range(0, 3);
      repeat (n) begin
        do b = DATA_W'($urandom_range(0, 255)); while (b == M_BYTE);
        send_byte(b, stray_start());
      end
      send_byte(M_BYTE, stray_start());
    end else begin
      send_byte(DATA_W'($urandom_range(0, 255)), ls);
    end
  endtask

  initial begin
    logic dark_seq[4];
    logic show_seq[4];
    int   target;
    dark_seq = '{1'b0, 1'b1, 1'b1, 1'b0};
    show_seq = '{1'b0, 1'b1, 1'b0, 1'b1};
    calm         = 1'b0;
    hold_request = 1'b0;
    bytes_sent   = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.line_start <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_DARK_ONLY;
    cfg_wdata        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines with hidden-text flagging on and bright bold colors.
    set_config(1'b0, 1'b1);
    send_line(first_line);
    send_line(second_line);
    settle();

    // Random phases, each under its own register setting. Every phase ends
    // with the sender waiting until all glyphs have come back.
    target = bytes_sent;
    for (int p = 0; p < 4; p++) begin
      set_config(dark_seq[p], show_seq[p]);
      target += PHASE_BYTES;
      if (p == 1) begin
        // The receiver holds off for a long stretch while printable bytes
        // keep coming back to back, so the block fills and stalls its input.
        calm = 1'b1;
        hold_request = 1'b1;
        repeat (24) send_byte(DATA_W'($urandom_range(8'h20, 8'h7E)), 1'b0);
        calm = 1'b0;
      end
      if (p == 2) begin
        // A stretch where neither side idles at all.
        calm = 1'b1;
        while (bytes_sent < target - 250) send_chunk();
        calm = 1'b0;
      end
      while (bytes_sent < target) send_chunk();
      settle();
    end

    repeat (8) @(posedge clk);
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
